>>> hw/rtl/bjs_pkg.sv
`default_nettype none

package bjs_pkg;

    localparam int unsigned DLY_W   = 32;  // deadline, period, jitter outputs
    localparam int unsigned BASE_W  = 31;
    localparam int unsigned CNT_W   = 6;
    localparam int unsigned PCT_W   = 7;
    localparam int unsigned RND_W   = 31;
    localparam int unsigned PROD_W  = DLY_W + PCT_W;   // deadline * percent
    localparam int unsigned BOUND_W = 33;              // product / 100 + 1
    localparam int unsigned PCT_DIV = 100;
    localparam int unsigned QREM_W  = 7;               // remainder below 100
    localparam int unsigned SH_W    = 5;

    // request opcodes
    localparam logic OP_NEXT    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef enum logic [1:0] {
        CFG_BASE_DELAY     = 2'd0,
        CFG_MAX_RETRIES    = 2'd1,
        CFG_CAPPED_DELAY   = 2'd2,
        CFG_JITTER_PERCENT = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic             op;
        logic [RND_W-1:0] random_word;
    } in_t;

    typedef struct packed {
        logic [DLY_W-1:0] retry_period;
        logic [DLY_W-1:0] deadline_used;
        logic [DLY_W-1:0] jitter_drawn;
        logic [CNT_W-1:0] retries_done;
        logic             exhausted;
        logic             clamped;
        logic             saturated;
        logic [DLY_W-1:0] expiration_time;
    } out_t;

    typedef struct packed {
        logic [DLY_W-1:0] val;
        logic             sat;
    } shl_t;

    // value << sh, saturated to 32 bits
    function automatic shl_t shl_sat(input logic [BASE_W-1:0] value,
                                     input logic [CNT_W-1:0]  sh);
        logic [DLY_W+BASE_W-1:0] wide;
        shl_t                    r;
        wide = (DLY_W+BASE_W)'(value) << sh[SH_W-1:0];
        if (value == '0) begin
            r.val = '0;
            r.sat = 1'b0;
        end else if (sh[CNT_W-1] || (|wide[DLY_W+BASE_W-1:DLY_W])) begin
            r.val = '1;
            r.sat = 1'b1;
        end else begin
            r.val = wide[DLY_W-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bjs_div100.sv
`default_nettype none

// Restoring divide by 100, one quotient bit per cycle.
module bjs_div100 (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [bjs_pkg::PROD_W-1:0]   dividend,
    output logic                              done,
    output logic [bjs_pkg::PROD_W-1:0]        quotient
);

    localparam int unsigned CW = $clog2(bjs_pkg::PROD_W + 1);

    logic [bjs_pkg::PROD_W-1:0] sh_reg;
    logic [bjs_pkg::QREM_W-1:0] rem_reg;
    logic [bjs_pkg::QREM_W-1:0] rem_next;
    logic [bjs_pkg::QREM_W:0]   trial;
    logic                       ge;
    logic [CW-1:0]              cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    always_comb begin
        trial    = {rem_reg, sh_reg[bjs_pkg::PROD_W-1]};
        ge       = trial >= (bjs_pkg::QREM_W+1)'(bjs_pkg::PCT_DIV);
        rem_next = ge ? bjs_pkg::QREM_W'(trial - (bjs_pkg::QREM_W+1)'(bjs_pkg::PCT_DIV))
                      : bjs_pkg::QREM_W'(trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                sh_reg   <= dividend;
                rem_reg  <= '0;
                cnt_reg  <= CW'(bjs_pkg::PROD_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                sh_reg  <= {sh_reg[bjs_pkg::PROD_W-2:0], ge};
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = sh_reg;

endmodule

`default_nettype wire

>>> hw/rtl/bjs_mod.sv
`default_nettype none

// Restoring modulo, one dividend bit per cycle. The partial remainder
// never exceeds the bits shifted in so far, so it stays 31 bits wide.
module bjs_mod (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [bjs_pkg::RND_W-1:0]     dividend,
    input  wire logic [bjs_pkg::BOUND_W-1:0]   divisor,
    output logic                               done,
    output logic [bjs_pkg::RND_W-1:0]          remainder
);

    localparam int unsigned CW = $clog2(bjs_pkg::RND_W + 1);

    logic [bjs_pkg::RND_W-1:0]   sh_reg;
    logic [bjs_pkg::RND_W-1:0]   rem_reg;
    logic [bjs_pkg::BOUND_W-1:0] div_reg;
    logic [bjs_pkg::RND_W:0]     trial;
    logic                        ge;
    logic [CW-1:0]               cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    always_comb begin
        trial = {rem_reg, sh_reg[bjs_pkg::RND_W-1]};
        ge    = bjs_pkg::BOUND_W'(trial) >= div_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                sh_reg   <= dividend;
                div_reg  <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= CW'(bjs_pkg::RND_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                sh_reg  <= {sh_reg[bjs_pkg::RND_W-2:0], 1'b0};
                rem_reg <= ge ? bjs_pkg::RND_W'(bjs_pkg::BOUND_W'(trial) - div_reg)
                              : bjs_pkg::RND_W'(trial);
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> hw/rtl/backoff_retry_jitter_scheduler.sv
// Sequence: a retry request runs S_EXP, S_DSTART, the bit-serial divide by 100 in S_DIV,
//   the modulo in S_MOD, then S_ACC and S_FIN; a restart goes from S_EXP to S_ACC.
// Throughput: one request at a time; the next is taken in the cycle after the result is
//   loaded into the output register, and loading waits while a result is held and not taken.
// Reset: synchronous active-low aresetn; registers return to base 1, max retries 5,
//   cap 0, percent 0, retry count and jitter total zero, output empty.
`default_nettype none

module backoff_retry_jitter_scheduler (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // request channel
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire bjs_pkg::in_t         s_data,
    // result channel
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output bjs_pkg::out_t             m_data,
    // register writes
    input  wire logic                 cfg_wr_en,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [31:0]          cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,    // wait for a request; pick deadline, advance or clear retry count
        S_EXP,     // deadline * percent, expiration time
        S_DSTART,  // kick the divide by 100
        S_DIV,     // wait for quotient, then kick the modulo
        S_MOD,     // wait for the jitter
        S_ACC,     // accumulate jitter with saturation
        S_FIN      // compare, load output register
    } state_t;

    state_t state_reg;

    // register file
    logic [bjs_pkg::BASE_W-1:0] base_reg;
    logic [bjs_pkg::CNT_W-1:0]  max_reg;
    logic [bjs_pkg::DLY_W-1:0]  capped_reg;
    logic [bjs_pkg::PCT_W-1:0]  pct_reg;

    // sequence state
    logic [bjs_pkg::CNT_W-1:0]  count_reg;
    logic [bjs_pkg::DLY_W-1:0]  total_reg;

    // per-request working registers
    logic                       restart_reg;
    logic [bjs_pkg::RND_W-1:0]  rnd_reg;
    logic [bjs_pkg::DLY_W-1:0]  deadline_reg;
    logic                       sat_reg;
    logic                       exh_reg;
    logic [bjs_pkg::PROD_W-1:0] prod_reg;
    logic [bjs_pkg::RND_W-1:0]  jitter_reg;
    logic [bjs_pkg::DLY_W-1:0]  exp_reg;

    logic                       m_valid_reg;
    bjs_pkg::out_t              m_data_reg;

    // shared shifter: retry count while idle, max retries for expiration
    logic [bjs_pkg::CNT_W-1:0]  sh_amt;
    bjs_pkg::shl_t              shl;

    logic                       accept;
    logic                       exh_now;
    logic                       cap_pos;
    logic [bjs_pkg::DLY_W:0]    sum;
    logic                       clamped;
    logic                       out_free;

    logic                       div_start;
    logic                       div_done;
    logic [bjs_pkg::PROD_W-1:0] div_q;
    logic                       mod_start;
    logic                       mod_done;
    logic [bjs_pkg::RND_W-1:0]  mod_rem;
    logic [bjs_pkg::BOUND_W-1:0] bound;

    always_comb begin
        accept    = s_valid && (state_reg == S_IDLE);
        sh_amt    = (state_reg == S_IDLE) ? count_reg : max_reg;
        shl       = bjs_pkg::shl_sat(base_reg, sh_amt);
        exh_now   = count_reg >= max_reg;
        // cap counts only when strictly positive
        cap_pos   = !capped_reg[bjs_pkg::DLY_W-1] && (capped_reg != '0);
        sum       = (bjs_pkg::DLY_W+1)'(total_reg) + (bjs_pkg::DLY_W+1)'(jitter_reg);
        clamped   = total_reg > deadline_reg;
        out_free  = !m_valid_reg || m_ready;
        div_start = (state_reg == S_DSTART);
        // bound = product / 100 + 1, fits in 33 bits
        bound     = div_q[bjs_pkg::BOUND_W-1:0] + bjs_pkg::BOUND_W'(1);
        mod_start = (state_reg == S_DIV) && div_done;
    end

    bjs_div100 u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    bjs_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (rnd_reg),
        .divisor   (bound),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg   <= bjs_pkg::BASE_W'(1);
            max_reg    <= bjs_pkg::CNT_W'(5);
            capped_reg <= '0;
            pct_reg    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bjs_pkg::CFG_BASE_DELAY:     base_reg   <= cfg_wdata[bjs_pkg::BASE_W-1:0];
                bjs_pkg::CFG_MAX_RETRIES:    max_reg    <= cfg_wdata[bjs_pkg::CNT_W-1:0];
                bjs_pkg::CFG_CAPPED_DELAY:   capped_reg <= cfg_wdata[bjs_pkg::DLY_W-1:0];
                bjs_pkg::CFG_JITTER_PERCENT: pct_reg    <= cfg_wdata[bjs_pkg::PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer, sequence state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // taken result leaves unless a new one is loaded this cycle
            if (m_ready && !((state_reg == S_FIN) && out_free)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        restart_reg <= (s_data.op == bjs_pkg::OP_RESTART);
                        rnd_reg     <= s_data.random_word;
                        jitter_reg  <= '0;
                        if (s_data.op == bjs_pkg::OP_RESTART) begin
                            // restart: count, jitter total and deadline read zero
                            count_reg    <= '0;
                            total_reg    <= '0;
                            deadline_reg <= '0;
                            sat_reg      <= 1'b0;
                            exh_reg      <= 1'b0;
                        end else if (exh_now) begin
                            // budget used up: cap or base, jitter starts over
                            total_reg    <= '0;
                            deadline_reg <= cap_pos ? capped_reg
                                                    : bjs_pkg::DLY_W'(base_reg);
                            sat_reg      <= 1'b0;
                            exh_reg      <= 1'b1;
                        end else begin
                            count_reg    <= count_reg + bjs_pkg::CNT_W'(1);
                            deadline_reg <= shl.val;
                            sat_reg      <= shl.sat;
                            exh_reg      <= 1'b0;
                        end
                        state_reg <= S_EXP;
                    end
                end
                S_EXP: begin
                    prod_reg  <= bjs_pkg::PROD_W'(deadline_reg) * bjs_pkg::PROD_W'(pct_reg);
                    exp_reg   <= shl.val;
                    state_reg <= restart_reg ? S_ACC : S_DSTART;
                end
                S_DSTART: begin
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        state_reg <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (mod_done) begin
                        jitter_reg <= mod_rem;
                        state_reg  <= S_ACC;
                    end
                end
                S_ACC: begin
                    // jitter total saturates at all ones
                    total_reg <= sum[bjs_pkg::DLY_W] ? '1 : sum[bjs_pkg::DLY_W-1:0];
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        m_valid_reg                <= 1'b1;
                        m_data_reg.retry_period    <= clamped ? '0 : deadline_reg - total_reg;
                        m_data_reg.deadline_used   <= deadline_reg;
                        m_data_reg.jitter_drawn    <= bjs_pkg::DLY_W'(jitter_reg);
                        m_data_reg.retries_done    <= count_reg;
                        m_data_reg.exhausted       <= exh_reg;
                        m_data_reg.clamped         <= clamped;
                        m_data_reg.saturated       <= sat_reg;
                        m_data_reg.expiration_time <= exp_reg;
                        state_reg                  <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // one request in flight: acceptance closes the input side
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in flight");

    // a clamped period is zero
    a_clamp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.clamped) |-> (m_data.retry_period == '0))
        else $error("clamped result with nonzero period");

    // saturation only on the doubling path
    a_sat_not_exh: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.exhausted) |-> !m_data.saturated)
        else $error("saturated flag on exhausted result");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

`default_nettype wire
